>>> src/brpm_pkg.sv
// Shared types and constants for the block RMS and peak meter.
`timescale 1ns / 1ps
package brpm_pkg;
    typedef struct packed {
        logic        command;
        logic [2:0]  channel;
        logic signed [23:0] sample;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  out_channel;
        logic [23:0] rms_level;
        logic [23:0] peak_level;
        logic        clip_flag;
    } t_out_item;

    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_CLEAR_CLIP = 1'b1;

    localparam int SUM_W  = 64;
    localparam int CNT_W  = 17;
    localparam int ROOT_W = 32;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic root_start;
        logic root_step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic is_block_end;
        logic div_done;
        logic root_done;
    } t_status;
endpackage

>>> src/brpm_ctrl.sv
// Controller sequencing accumulate, divide, root and result hand-off.
`timescale 1ns / 1ps
module brpm_ctrl
    import brpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_out_busy,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_PUB  = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                o_cmd.load = i_valid;
                if (i_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.is_block_end) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_stall = 1'b0;
                    o_cmd.load = i_valid;
                    n_state = i_valid ? S_LOAD : S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_step   = 1'b0;
                    o_cmd.root_start = 1'b1;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_done) begin
                    o_cmd.root_step = 1'b0;
                    n_state = S_PUB;
                end
            end
            S_PUB: begin
                if (!i_out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> src/brpm_datapath.sv
// Datapath: channel accumulators, serial divider and serial square root.
`timescale 1ns / 1ps
module brpm_datapath
    import brpm_pkg::*;
#(
    parameter int CHANNELS  = 8,
    parameter int MAX_BLOCK = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_item o_result
);
    localparam int W   = 24;
    localparam int CHW = 3;
    localparam logic [23:0] ONE = 24'd2097152;

    logic [SUM_W-1:0] r_sum  [CHANNELS];
    logic [CNT_W-1:0] r_cnt  [CHANNELS];
    logic [W-1:0]     r_peak [CHANNELS];
    logic             r_clip;

    // stage 1: captured item and magnitude
    t_in_item    r_item;
    logic [W-1:0] r_mag;
    logic        r_hit;
    logic [W-1:0] mag;

    assign mag = i_item.sample[W-1] ? (~i_item.sample + 1'b1) : i_item.sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_cmd.load;
        end
        if (i_cmd.load) begin
            r_item <= i_item;
            r_mag  <= mag;
        end
    end

    logic ch_ok;
    logic [CHW-1:0] ch;
    assign ch    = r_item.channel;
    assign ch_ok = 32'(ch) < CHANNELS;

    logic [47:0] sq;
    assign sq = r_mag * r_mag;

    logic [SUM_W:0] sum_add;
    logic [SUM_W-1:0] cur_sum;
    logic [CNT_W-1:0] cur_cnt;
    logic [W-1:0] cur_peak;
    assign cur_sum  = ch_ok ? r_sum[ch]  : '0;
    assign cur_cnt  = ch_ok ? r_cnt[ch]  : '0;
    assign cur_peak = ch_ok ? r_peak[ch] : '0;
    assign sum_add  = {1'b0, cur_sum} + {{(SUM_W-48+1){1'b0}}, sq};

    logic do_sample;
    assign do_sample = r_hit && r_item.command == CMD_SAMPLE && ch_ok;
    logic counting;
    assign counting = 32'(cur_cnt) < MAX_BLOCK;

    logic [SUM_W-1:0] new_sum;
    logic [CNT_W-1:0] new_cnt;
    logic [W-1:0]     new_peak;
    assign new_sum  = !counting ? cur_sum : (sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0]);
    assign new_cnt  = counting ? cur_cnt + 1'b1 : cur_cnt;
    assign new_peak = (r_mag > cur_peak) ? r_mag : cur_peak;

    assign o_status.is_block_end = do_sample && r_item.last;

    // serial divider and root registers
    logic [SUM_W-1:0] r_num, r_rem_d;
    logic [CNT_W-1:0] r_den;
    logic [6:0]       r_dcnt;
    logic [SUM_W-1:0] r_q;
    logic [SUM_W-1:0] r_x, r_res, r_bit;
    logic [CHW-1:0]   r_och;
    logic [W-1:0]     r_opeak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i]  <= '0;
                r_cnt[i]  <= '0;
                r_peak[i] <= '0;
            end
            r_clip <= 1'b0;
        end else if (r_hit) begin
            if (r_item.command == CMD_CLEAR_CLIP) begin
                r_clip <= 1'b0;
            end else if (ch_ok) begin
                if (r_mag >= ONE) r_clip <= 1'b1;
                if (r_item.last) begin
                    r_sum[ch]  <= '0;
                    r_cnt[ch]  <= '0;
                    r_peak[ch] <= '0;
                end else begin
                    r_sum[ch]  <= new_sum;
                    r_cnt[ch]  <= new_cnt;
                    r_peak[ch] <= new_peak;
                end
            end
        end
    end

    logic [SUM_W:0] rem_sh;
    assign rem_sh = {r_rem_d, r_num[SUM_W-1]};
    logic [SUM_W-1:0] rb;
    assign rb = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_num   <= new_sum;
            r_den   <= new_cnt;
            r_rem_d <= '0;
            r_q     <= '0;
            r_dcnt  <= 7'(SUM_W);
            r_och   <= ch;
            r_opeak <= new_peak;
        end else if (i_cmd.div_step) begin
            r_num  <= r_num << 1;
            r_dcnt <= r_dcnt - 1'b1;
            if (rem_sh >= {{(SUM_W-CNT_W+1){1'b0}}, r_den}) begin
                r_rem_d <= SUM_W'(rem_sh - {{(SUM_W-CNT_W+1){1'b0}}, r_den});
                r_q     <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem_d <= rem_sh[SUM_W-1:0];
                r_q     <= {r_q[SUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.root_start) begin
            r_x   <= r_q;
            r_res <= '0;
            r_bit <= {2'b01, {(SUM_W-2){1'b0}}};
        end else if (i_cmd.root_step) begin
            r_bit <= r_bit >> 2;
            if (r_x >= rb) begin
                r_x   <= r_x - rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_status.div_done  = r_dcnt == 7'd0;
    assign o_status.root_done = r_bit == '0;

    assign o_result.out_channel = r_och;
    assign o_result.rms_level   = r_res[W-1:0];
    assign o_result.peak_level  = r_opeak;
    assign o_result.clip_flag   = r_clip;
endmodule

>>> src/block_rms_peak_meter.sv
// Top level of the block RMS and peak meter.
//  channel | direction | handshake            | payload
//  in      | into      | i_valid / o_stall    | i_item (t_in_item)
//  out     | out of    | o_valid / i_stall    | o_item (t_out_item)
// Samples stream back to back until a block end stalls the input.
// A block end stalls the input while its sample is accumulated, a serial divide and a serial
// root run and the result is published; a held result extends the publish.
// Reset is synchronous, active low, and clears all channel state and the clip flag.
// The result register holds while a valid result is held by i_stall.
`timescale 1ns / 1ps
module block_rms_peak_meter
    import brpm_pkg::*;
#(
    parameter int CHANNELS  = 8,
    parameter int MAX_BLOCK = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    t_cmd      cmd;
    t_status   status;
    t_out_item result;
    logic      r_valid;

    brpm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_out_busy(r_valid && i_stall),
        .i_status(status), .o_cmd(cmd)
    );

    brpm_datapath #(.CHANNELS(CHANNELS), .MAX_BLOCK(MAX_BLOCK)) u_dp (
        .i_clk, .i_rst_n, .i_item, .i_cmd(cmd), .o_status(status), .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (cmd.publish) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (cmd.publish) o_item <= result;
    end
    assign o_valid = r_valid;

`ifndef SYNTHESIS
    a_pub_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> !(r_valid && i_stall)) else $error("publish over held result");
    a_div_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.div_step && cmd.root_step)) else $error("divide and root overlap");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
`endif
endmodule

>>> dv/block_rms_peak_meter_test.sv
// Testbench for the block RMS and peak meter: directed table, a longer block, then random transfers.
`timescale 1ns / 1ps
module block_rms_peak_meter_test;
    import brpm_pkg::*;

    localparam int NCH = 8;
    localparam int MAXB = 4096;
    localparam int ONE = 2097152;
    localparam int WATCH = 20000;

    typedef struct packed {
        t_in_item  item;
        logic      fixed;
        t_out_item res;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_item;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_item;

    logic [63:0] sq_sum [NCH];
    int          n_samp [NCH];
    logic [23:0] pk [NCH];
    logic        clip;
    t_out_item   level_q[$];
    int          errors;
    int          src_idle;
    int          snk_idle;
    int          hold_off;
    int          quiet;
    bit          done;
    t_row        rows[$];

    block_rms_peak_meter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void predict_level(t_in_item it);
        logic [23:0] mag;
        logic [63:0] sq;
        t_out_item   r;
        int          c;
        if (it.command == CMD_CLEAR_CLIP) begin
            clip = 1'b0;
            return;
        end
        c = it.channel;
        mag = it.sample[23] ? 24'(-it.sample) : it.sample;
        if (it.sample == 24'sh800000) mag = 24'h800000;
        if (n_samp[c] < MAXB) begin
            sq = 64'(mag) * 64'(mag);
            sq_sum[c] = (sq_sum[c] > ~64'd0 - sq) ? ~64'd0 : sq_sum[c] + sq;
            n_samp[c]++;
        end
        if (mag > pk[c]) pk[c] = mag;
        if (mag >= ONE) clip = 1'b1;
        if (!it.last) return;
        r.out_channel = it.channel;
        r.rms_level = 24'(isqrt(n_samp[c] ? sq_sum[c] / 64'(n_samp[c]) : 64'd0));
        r.peak_level = pk[c];
        r.clip_flag = clip;
        level_q.push_back(r);
        sq_sum[c] = 0;
        n_samp[c] = 0;
        pk[c] = 0;
    endfunction

    function automatic t_in_item mk(logic cmd, int ch, int s, logic lst);
        t_in_item it;
        it.command = cmd;
        it.channel = 3'(ch);
        it.sample = 24'(s);
        it.last = lst;
        return it;
    endfunction

    function automatic t_out_item lv(int ch, int rms, int p, logic cf);
        t_out_item r;
        r.out_channel = 3'(ch);
        r.rms_level = 24'(rms);
        r.peak_level = 24'(p);
        r.clip_flag = cf;
        return r;
    endfunction

    task automatic add_row(t_in_item it, logic fx, t_out_item r);
        t_row w;
        w.item = it;
        w.fixed = fx;
        w.res = r;
        rows.push_back(w);
    endtask

    task automatic send(t_in_item it);
        while (($urandom_range(99) < src_idle)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_level(it);
    endtask

    task automatic send_row(t_row w);
        int n_prev;
        n_prev = level_q.size();
        send(w.item);
        if (w.fixed && level_q.size() > n_prev) level_q[$] = w.res;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (level_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_item(int ch);
        t_in_item it;
        int       k;
        it = mk(CMD_SAMPLE, ch, $urandom, $urandom_range(15) == 0);
        k = $urandom_range(9);
        if (k == 0) it.sample = 24'sh800000;
        else if (k == 1) it.sample = 24'(ONE);
        else if (k == 2) it.sample = 24'(-ONE);
        else if (k < 6) it.sample = 24'($signed($urandom_range(4095)) - 2048);
        if ($urandom_range(40) == 0) it.command = CMD_CLEAR_CLIP;
        return it;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send(rand_item($urandom_range(NCH - 1)));
        for (int c = 0; c < NCH; c++) send(mk(CMD_SAMPLE, c, $urandom, 1'b1));
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_off > 0) begin
            i_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (level_q.size() == 0) begin
                $display("%0t unexpected result %p", $time, o_item);
                errors++;
            end else begin
                if (o_item !== level_q[0]) begin
                    $display("%0t mismatch expected %p actual %p", $time, level_q[0], o_item);
                    errors++;
                end
                void'(level_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCH && !done) begin
            $display("block_rms_peak_meter test failed");
            $finish;
        end
    end

    initial begin
        t_in_item big;
        errors = 0;
        quiet = 0;
        done = 0;
        hold_off = 0;
        src_idle = 0;
        snk_idle = 0;
        clip = 0;
        for (int c = 0; c < NCH; c++) begin
            sq_sum[c] = 0;
            n_samp[c] = 0;
            pk[c] = 0;
        end
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(mk(CMD_SAMPLE, 0, 0, 1'b1), 1'b1, lv(0, 0, 0, 1'b0));
        add_row(mk(CMD_SAMPLE, 1, 8388607, 1'b1), 1'b1, lv(1, 8388607, 8388607, 1'b1));
        add_row(mk(CMD_CLEAR_CLIP, 5, -1, 1'b1), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 2, -8388608, 1'b1), 1'b1, lv(2, 8388608, 8388608, 1'b1));
        add_row(mk(CMD_CLEAR_CLIP, 0, 0, 1'b0), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 3, ONE - 1, 1'b1), 1'b1, lv(3, ONE - 1, ONE - 1, 1'b0));
        add_row(mk(CMD_SAMPLE, 4, -ONE, 1'b1), 1'b1, lv(4, ONE, ONE, 1'b1));
        add_row(mk(CMD_CLEAR_CLIP, 7, 0, 1'b0), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 7, 3, 1'b0), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 7, -4, 1'b0), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 6, 100, 1'b0), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 7, 5, 1'b1), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 6, -1, 1'b1), 1'b0, '0);
        add_row(mk(CMD_SAMPLE, 5, 1, 1'b1), 1'b1, lv(5, 1, 1, 1'b0));
        foreach (rows[i]) send_row(rows[i]);
        drain();

        // longer block with one loud sample late on
        src_idle = 0;
        snk_idle = 0;
        for (int i = 0; i < 40; i++) begin
            big = mk(CMD_SAMPLE, 1, (i == 37) ? -8388608 : 1000 + (i % 7), 1'b0);
            send(big);
        end
        send(mk(CMD_SAMPLE, 1, 5, 1'b1));
        drain();

        src_idle = 25;
        snk_idle = 86;
        random_phase(180);
        src_idle = 86;
        snk_idle = 25;
        random_phase(180);
        src_idle = 0;
        snk_idle = 0;
        hold_off = 3000;
        random_phase(180);

        done = 1;
        repeat (300) @(posedge i_clk);
        if (errors == 0 && level_q.size() == 0) begin
            $display("block_rms_peak_meter test passed");
        end else begin
            $display("block_rms_peak_meter test failed");
        end
        $finish;
    end
endmodule
